// File: hdl/lca_binary_lifting_top_assert.svh
// ----------------------------------------------------------------------------
// lca_binary_lifting_top_assert.svh
// Assertion macros shared by the checker of the lca binary lifting block.
// The macros expect signals named clk and rst in the using scope.
// ----------------------------------------------------------------------------
`ifndef LCA_BINARY_LIFTING_TOP_ASSERT_SVH
`define LCA_BINARY_LIFTING_TOP_ASSERT_SVH

// same-cycle implication, off during reset
`define LCA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off during reset
`define LCA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// next-cycle implication that also holds through reset
`define LCA_ASSERT_ALWAYS(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/lca_pkg.sv
// ----------------------------------------------------------------------------
// lca_pkg
// Word types and fixed constants of the lca binary lifting block.
// ----------------------------------------------------------------------------
package lca_pkg;

  // width of node numbers and depths
  localparam int FIELD_W = 10;

  // largest depth a node can hold
  localparam logic [FIELD_W-1:0] DEPTH_MAX = 10'd1023;

  // request kinds
  localparam logic KIND_ADD   = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  // request word
  typedef struct packed {
    logic               kind;
    logic [FIELD_W-1:0] node_a;
    logic [FIELD_W-1:0] node_b;
  } req_word_t;

  // response word
  typedef struct packed {
    logic [FIELD_W-1:0] ancestor;
    logic [FIELD_W-1:0] ancestor_depth;
  } rsp_word_t;

endpackage

// File: hdl/lca_ram.sv
// ----------------------------------------------------------------------------
// lca_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module lca_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// File: hdl/lca_binary_lifting_top.sv
// Lowest common ancestor by binary lifting over a jump table RAM and a depth RAM.
// Add word: back to idle after one base write, then one jump read and one jump write
//   per level above level zero.
// Query word: lookups share the single read port of the jump table RAM; one word in
//   flight at a time.
// Reset clears the sequencer and the response valid only; the RAMs are not swept.
// ----------------------------------------------------------------------------
// lca_binary_lifting_top
// Loads a rooted tree parent-first into a binary-lifting jump table and answers
// lowest common ancestor queries with a small sequencer around the RAMs.
// ----------------------------------------------------------------------------
module lca_binary_lifting_top #(
  parameter int NODES  = 1024,
  parameter int LEVELS = 10
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  input  lca_pkg::req_word_t req,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  output lca_pkg::rsp_word_t rsp
);

  import lca_pkg::*;

  localparam int NW = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int LW = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int JUMP_DEPTH = NODES << LW;
  localparam logic [16:0] NODE_LIMIT = 17'(NODES);
  localparam logic [LW-1:0] LVL_TOP = LW'(LEVELS - 1);

  typedef enum logic [4:0] {
    IDLE,
    ADD_DEP,
    ADD_BASE,
    ADD_RD,
    ADD_WR,
    Q_DA,
    Q_DB,
    L_CHK,
    L_JMP,
    L_DEP,
    J_RA,
    J_RB,
    J_CMP,
    F_CHK,
    F_PAR,
    F_DEP,
    F_OUT
  } state_t;

  state_t state;

  // working registers
  logic [FIELD_W-1:0] a;
  logic [FIELD_W-1:0] b;
  logic [FIELD_W-1:0] da;
  logic [FIELD_W-1:0] db;
  logic [FIELD_W-1:0] ja;
  logic [LW-1:0]      lvl;

  // RAM ports
  logic               j_we;
  logic [NW+LW-1:0]   j_waddr;
  logic [FIELD_W-1:0] j_wdata;
  logic [NW+LW-1:0]   j_raddr;
  logic [FIELD_W-1:0] j_rdata;
  logic               d_we;
  logic [NW-1:0]      d_waddr;
  logic [FIELD_W-1:0] d_wdata;
  logic [NW-1:0]      d_raddr;
  logic [FIELD_W-1:0] d_rdata;

  logic               bad_node;
  logic               lift_ok;
  logic [FIELD_W-1:0] dep_inc;

  lca_ram #(.WIDTH(FIELD_W), .DEPTH(JUMP_DEPTH)) u_jump_ram (
    .clk     (clk),
    .wr_en   (j_we),
    .wr_addr (j_waddr),
    .wr_data (j_wdata),
    .rd_addr (j_raddr),
    .rd_data (j_rdata)
  );

  lca_ram #(.WIDTH(FIELD_W), .DEPTH(NODES)) u_depth_ram (
    .clk     (clk),
    .wr_en   (d_we),
    .wr_addr (d_waddr),
    .wr_data (d_wdata),
    .rd_addr (d_raddr),
    .rd_data (d_rdata)
  );

  assign req_ready = (state == IDLE);

  // node number range check
  assign bad_node = ({7'd0, req.node_a} >= NODE_LIMIT) || ({7'd0, req.node_b} >= NODE_LIMIT);

  // compare: may a climb 2^lvl without passing b's depth
  assign lift_ok = {7'd0, da} >= ({7'd0, db} + (17'd1 << lvl));

  // parent depth plus one, saturating
  assign dep_inc = (d_rdata == DEPTH_MAX) ? DEPTH_MAX : d_rdata + 10'd1;

  // RAM address and write control per sequencer step
  always_comb begin
    j_we    = 1'b0;
    j_waddr = '0;
    j_wdata = '0;
    j_raddr = '0;
    d_we    = 1'b0;
    d_waddr = '0;
    d_wdata = '0;
    d_raddr = '0;
    case (state)
      IDLE: begin
        d_raddr = (req.kind == KIND_QUERY) ? NW'(req.node_a) : NW'(req.node_b);
      end
      Q_DA: begin
        d_raddr = NW'(b);
      end
      ADD_BASE: begin
        d_we    = 1'b1;
        d_waddr = NW'(a);
        d_wdata = da;
        j_we    = 1'b1;
        j_waddr = {NW'(a), {LW{1'b0}}};
        j_wdata = b;
      end
      ADD_RD: begin
        j_raddr = {NW'(b), LW'(lvl - LW'(1))};
      end
      ADD_WR: begin
        j_we    = 1'b1;
        j_waddr = {NW'(a), lvl};
        j_wdata = j_rdata;
      end
      L_CHK: begin
        j_raddr = {NW'(a), lvl};
      end
      L_JMP: begin
        d_raddr = NW'(j_rdata);
      end
      J_RA: begin
        j_raddr = {NW'(a), lvl};
      end
      J_RB: begin
        j_raddr = {NW'(b), lvl};
      end
      F_CHK: begin
        j_raddr = {NW'(a), {LW{1'b0}}};
        d_raddr = NW'(a);
      end
      F_PAR: begin
        d_raddr = NW'(j_rdata);
      end
      default: begin
        j_we = 1'b0;
      end
    endcase
  end

  // sequencer and response register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      rsp_valid <= 1'b0;
    end else begin
      // the output step reloads the response itself
      if (rsp_valid && rsp_ready && state != F_OUT) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        IDLE: begin
          if (req_valid) begin
            a <= req.node_a;
            b <= req.node_b;
            if (!bad_node) begin
              if (req.kind == KIND_QUERY) begin
                state <= Q_DA;
              end else if (req.node_a == req.node_b) begin
                da    <= '0;
                state <= ADD_BASE;
              end else begin
                state <= ADD_DEP;
              end
            end
          end
        end
        ADD_DEP: begin
          da    <= dep_inc;
          state <= ADD_BASE;
        end
        ADD_BASE: begin
          lvl   <= LW'(1);
          state <= (LEVELS > 1) ? ADD_RD : IDLE;
        end
        ADD_RD: begin
          state <= ADD_WR;
        end
        ADD_WR: begin
          b <= j_rdata;
          if (lvl == LVL_TOP) begin
            state <= IDLE;
          end else begin
            lvl   <= lvl + LW'(1);
            state <= ADD_RD;
          end
        end
        Q_DA: begin
          da    <= d_rdata;
          state <= Q_DB;
        end
        Q_DB: begin
          // keep the deeper node in a
          if (da < d_rdata) begin
            a  <= b;
            b  <= a;
            da <= d_rdata;
            db <= da;
          end else begin
            db <= d_rdata;
          end
          lvl   <= LVL_TOP;
          state <= L_CHK;
        end
        L_CHK: begin
          if (lift_ok) begin
            state <= L_JMP;
          end else if (lvl == '0) begin
            lvl   <= LVL_TOP;
            state <= J_RA;
          end else begin
            lvl <= lvl - LW'(1);
          end
        end
        L_JMP: begin
          a     <= j_rdata;
          state <= L_DEP;
        end
        L_DEP: begin
          da <= d_rdata;
          if (lvl == '0) begin
            lvl   <= LVL_TOP;
            state <= J_RA;
          end else begin
            lvl   <= lvl - LW'(1);
            state <= L_CHK;
          end
        end
        J_RA: begin
          state <= J_RB;
        end
        J_RB: begin
          ja    <= j_rdata;
          state <= J_CMP;
        end
        J_CMP: begin
          // climb both while the ancestors differ
          if (ja != j_rdata) begin
            a <= ja;
            b <= j_rdata;
          end
          if (lvl == '0) begin
            state <= F_CHK;
          end else begin
            lvl   <= lvl - LW'(1);
            state <= J_RA;
          end
        end
        F_CHK: begin
          state <= (a != b) ? F_PAR : F_DEP;
        end
        F_PAR: begin
          a     <= j_rdata;
          state <= F_DEP;
        end
        F_DEP: begin
          da    <= d_rdata;
          state <= F_OUT;
        end
        F_OUT: begin
          if (!rsp_valid || rsp_ready) begin
            rsp.ancestor       <= a;
            rsp.ancestor_depth <= da;
            rsp_valid          <= 1'b1;
            state              <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule

// File: hdl/lca_checker.sv
// ----------------------------------------------------------------------------
// lca_checker
// Port-level checks on the lca binary lifting block, bound to the top level.
// ----------------------------------------------------------------------------
`include "lca_binary_lifting_top_assert.svh"

module lca_checker (
  input logic               clk,
  input logic               rst,
  input logic               req_valid,
  input logic               req_ready,
  input logic               rsp_valid,
  input logic               rsp_ready,
  input lca_pkg::rsp_word_t rsp
);

  import lca_pkg::*;

  // no response word survives reset
  `LCA_ASSERT_ALWAYS(a_rst_clears_rsp, rst, !rsp_valid, "response valid after reset")

  // a stalled response word holds
  `LCA_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp), "stalled word changed")

  // a result never appears the cycle right after a request word is taken
  `LCA_ASSERT_NOW(a_no_instant_rsp, $rose(rsp_valid), !$past(req_valid && req_ready), "instant response")

  // ready drops only when a request word was taken
  `LCA_ASSERT_NOW(a_ready_drop, $fell(req_ready), $past(req_valid), "ready fell without a request word")

endmodule

bind lca_binary_lifting_top lca_checker u_lca_checker (.*);

// File: verif/tb_lca_binary_lifting_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_lca_binary_lifting_top
// Loads rooted trees parent-first into the lca block and checks every query
// answer against a fixed want or a behavioral copy of the jump table and depth
// store kept in the bench. A short table of hand-picked words comes first, then
// random forests under uneven backpressure, then one chain through all nodes
// that drives the depth to saturation and the lifts to their longest gaps.
// ----------------------------------------------------------------------------
module tb_lca_binary_lifting_top;
  import lca_pkg::*;

  localparam int NODES        = 1024;
  localparam int LEVELS       = 10;
  localparam int RANDOM_WORDS = 210;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 6 * LEVELS + 20;
  localparam int CYCLE_LIMIT  = 1000000;

  // one row of the directed table; want is used only where fixed is set
  typedef struct packed {
    logic               kind;
    logic [FIELD_W-1:0] node_a;
    logic [FIELD_W-1:0] node_b;
    logic               fixed;
    rsp_word_t          want;
  } plan_row_t;

  logic      clk;
  logic      rst;
  logic      req_valid;
  logic      req_ready;
  req_word_t req;
  logic      rsp_valid;
  logic      rsp_ready;
  rsp_word_t rsp;

  // bench copy of the tree
  logic [FIELD_W-1:0] ancestor_hops [NODES][LEVELS];
  logic [FIELD_W-1:0] node_level [NODES];
  bit                 is_loaded [NODES];
  int                 loaded_nodes [$];
  int                 recent_nodes [$];

  rsp_word_t pending_answers [$];
  int        error_count;
  int        words_seen;
  int        cycle_count;
  int        send_idle_pct;
  int        rcv_idle_pct;
  int        hold_left;
  bit        hold_done;

  plan_row_t plan [21] = '{
    '{KIND_ADD,   10'd0,    10'd0,    1'b0, '0},
    '{KIND_QUERY, 10'd0,    10'd0,    1'b1, '{10'd0, 10'd0}},
    '{KIND_ADD,   10'd1023, 10'd0,    1'b0, '0},
    '{KIND_QUERY, 10'd1023, 10'd1023, 1'b1, '{10'd1023, 10'd1}},
    '{KIND_QUERY, 10'd1023, 10'd0,    1'b1, '{10'd0, 10'd0}},
    '{KIND_QUERY, 10'd0,    10'd1023, 1'b1, '{10'd0, 10'd0}},
    '{KIND_ADD,   10'd512,  10'd1023, 1'b0, '0},
    '{KIND_ADD,   10'd1,    10'd0,    1'b0, '0},
    '{KIND_QUERY, 10'd512,  10'd1,    1'b1, '{10'd0, 10'd0}},
    '{KIND_QUERY, 10'd512,  10'd1023, 1'b1, '{10'd1023, 10'd1}},
    '{KIND_ADD,   10'd341,  10'd512,  1'b0, '0},
    '{KIND_ADD,   10'd682,  10'd1,    1'b0, '0},
    '{KIND_QUERY, 10'd341,  10'd682,  1'b1, '{10'd0, 10'd0}},
    '{KIND_QUERY, 10'd341,  10'd512,  1'b1, '{10'd512, 10'd2}},
    // second root, then a query across the two trees
    '{KIND_ADD,   10'd2,    10'd2,    1'b0, '0},
    '{KIND_QUERY, 10'd2,    10'd341,  1'b0, '0},
    // reload the root under its own descendant, making a cycle
    '{KIND_ADD,   10'd0,    10'd341,  1'b0, '0},
    '{KIND_QUERY, 10'd682,  10'd1023, 1'b0, '0},
    '{KIND_QUERY, 10'd341,  10'd0,    1'b0, '0},
    '{KIND_ADD,   10'd0,    10'd0,    1'b0, '0},
    '{KIND_QUERY, 10'd1023, 10'd682,  1'b0, '0}
  };

  lca_binary_lifting_top dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  // clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // record a node: depth from the parent, jumps built level by level
  task automatic load_node(input logic [FIELD_W-1:0] node, input logic [FIELD_W-1:0] par);
    logic [FIELD_W-1:0] mid;
    int lvl;
    if (node == par) begin
      node_level[node] = '0;
    end else if (node_level[par] == DEPTH_MAX) begin
      node_level[node] = DEPTH_MAX;
    end else begin
      node_level[node] = node_level[par] + 1'b1;
    end
    ancestor_hops[node][0] = par;
    for (lvl = 1; lvl < LEVELS; lvl++) begin
      mid = ancestor_hops[node][lvl-1];
      ancestor_hops[node][lvl] = ancestor_hops[mid][lvl-1];
    end
  endtask

  // lift the deeper node, then both together, then one last parent step
  function automatic rsp_word_t common_ancestor(input logic [FIELD_W-1:0] a,
                                                input logic [FIELD_W-1:0] b);
    logic [FIELD_W-1:0] x;
    logic [FIELD_W-1:0] y;
    logic [FIELD_W-1:0] jx;
    logic [FIELD_W-1:0] jy;
    rsp_word_t answer;
    int i;
    x = a;
    y = b;
    if (node_level[x] < node_level[y]) begin
      x = b;
      y = a;
    end
    for (i = LEVELS - 1; i >= 0; i--) begin
      if (int'(node_level[x]) >= int'(node_level[y]) + (1 << i)) x = ancestor_hops[x][i];
    end
    for (i = LEVELS - 1; i >= 0; i--) begin
      jx = ancestor_hops[x][i];
      jy = ancestor_hops[y][i];
      if (jx != jy) begin
        x = jx;
        y = jy;
      end
    end
    if (x != y) x = ancestor_hops[x][0];
    answer.ancestor       = x;
    answer.ancestor_depth = node_level[x];
    return answer;
  endfunction

  function automatic int chain_at(input int start, input int stride, input int idx);
    return (start + idx * stride) % NODES;
  endfunction

  task automatic report_mismatch(input string what);
    if (error_count < 100) $display("[%0t] %s", $time, what);
    error_count++;
  endtask

  // offer one word, wait for it to be taken, then update the bench tree or queue the answer
  task automatic send_word(input req_word_t w, input logic fixed, input rsp_word_t want);
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= w;
    do @(posedge clk); while (!req_ready);
    if (w.kind == KIND_ADD) begin
      load_node(w.node_a, w.node_b);
      if (!is_loaded[w.node_a]) begin
        is_loaded[w.node_a] = 1'b1;
        loaded_nodes = {loaded_nodes, int'(w.node_a)};
      end
      recent_nodes = {recent_nodes, int'(w.node_a)};
      if (recent_nodes.size() > 4) void'(recent_nodes.pop_front());
    end else begin
      pending_answers = {pending_answers,
                         (fixed ? want : common_ancestor(w.node_a, w.node_b))};
    end
  endtask

  // mostly queries on loaded nodes and adds under loaded parents, biased to long chains
  task automatic pick_word(output req_word_t w);
    int roll;
    int tries;
    int n;
    roll = $urandom_range(99);
    if (loaded_nodes.size() == 0) begin
      n = $urandom_range(NODES - 1);
      w = '{KIND_ADD, n[FIELD_W-1:0], n[FIELD_W-1:0]};
    end else if (roll < 55) begin
      w.kind   = KIND_QUERY;
      w.node_a = FIELD_W'(loaded_nodes[$urandom_range(loaded_nodes.size() - 1)]);
      w.node_b = ($urandom_range(9) == 0) ? w.node_a
               : FIELD_W'(loaded_nodes[$urandom_range(loaded_nodes.size() - 1)]);
    end else begin
      w.kind = KIND_ADD;
      n = $urandom_range(NODES - 1);
      // fresh nodes usually, a reload now and then
      for (tries = 0; tries < 8 && roll < 88 && is_loaded[n]; tries++) begin
        n = $urandom_range(NODES - 1);
      end
      w.node_a = FIELD_W'(n);
      roll = $urandom_range(99);
      if (roll < 8) begin
        w.node_b = w.node_a;
      end else if (roll < 60 && recent_nodes.size() > 0) begin
        w.node_b = FIELD_W'(recent_nodes[$urandom_range(recent_nodes.size() - 1)]);
      end else begin
        w.node_b = FIELD_W'(loaded_nodes[$urandom_range(loaded_nodes.size() - 1)]);
      end
    end
  endtask

  // response side backpressure, with one long hold once results are flowing
  initial begin
    rsp_ready = 1'b0;
    hold_left = 0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (!hold_done && words_seen >= 40) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (rst) begin
        rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
        rsp_ready <= 1'b0;
        hold_left--;
      end else begin
        rsp_ready <= ($urandom_range(99) >= rcv_idle_pct);
      end
    end
  end

  // compare each taken word with the oldest pending answer
  always @(posedge clk) begin
    rsp_word_t want;
    if (!rst && rsp_valid && rsp_ready) begin
      if (pending_answers.size() == 0) begin
        report_mismatch($sformatf("unexpected word ancestor=%0d depth=%0d",
                                  rsp.ancestor, rsp.ancestor_depth));
      end else begin
        want = pending_answers.pop_front();
        if (rsp.ancestor !== want.ancestor)
          report_mismatch($sformatf("ancestor got %0d want %0d",
                                    rsp.ancestor, want.ancestor));
        if (rsp.ancestor_depth !== want.ancestor_depth)
          report_mismatch($sformatf("ancestor_depth got %0d want %0d",
                                    rsp.ancestor_depth, want.ancestor_depth));
      end
      words_seen++;
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // stimulus
  initial begin
    req_word_t w;
    int row;
    int start;
    int stride;
    int idx;
    rst           = 1'b1;
    req_valid     = 1'b0;
    req           = '0;
    error_count   = 0;
    words_seen    = 0;
    cycle_count   = 0;
    send_idle_pct = 22;
    rcv_idle_pct  = 65;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table
    for (row = 0; row < $size(plan); row++) begin
      w = '{plan[row].kind, plan[row].node_a, plan[row].node_b};
      send_word(w, plan[row].fixed, plan[row].want);
    end

    // random forests, sender light and receiver heavy
    repeat (RANDOM_WORDS) begin
      pick_word(w);
      send_word(w, 1'b0, '0);
    end

    // sender pauses until every answer is back
    req_valid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    @(posedge clk);

    // random forests, sender heavy and receiver light
    send_idle_pct = 65;
    rcv_idle_pct  = 22;
    repeat (RANDOM_WORDS) begin
      pick_word(w);
      send_word(w, 1'b0, '0);
    end

    // one chain through every node, no idling on either side
    send_idle_pct = 0;
    rcv_idle_pct  = 0;
    start  = $urandom_range(NODES - 1);
    stride = 2 * $urandom_range(NODES / 2 - 1) + 1;
    idx    = chain_at(start, stride, 0);
    w      = '{KIND_ADD, idx[FIELD_W-1:0], idx[FIELD_W-1:0]};
    send_word(w, 1'b0, '0);
    for (row = 1; row < NODES; row++) begin
      w = '{KIND_ADD, 10'(chain_at(start, stride, row)), 10'(chain_at(start, stride, row - 1))};
      send_word(w, 1'b0, '0);
      if (row % 8 == 0) begin
        w = '{KIND_QUERY, 10'(chain_at(start, stride, $urandom_range(row))),
              10'(chain_at(start, stride, $urandom_range(row)))};
        send_word(w, 1'b0, '0);
      end
    end
    // longest lifts in both orders
    w = '{KIND_QUERY, 10'(chain_at(start, stride, NODES - 1)), 10'(chain_at(start, stride, 0))};
    send_word(w, 1'b0, '0);
    w = '{KIND_QUERY, 10'(chain_at(start, stride, 0)), 10'(chain_at(start, stride, NODES - 1))};
    send_word(w, 1'b0, '0);
    // depth saturation: reload a node under the deepest one, then a child of it
    w = '{KIND_ADD, 10'(chain_at(start, stride, 5)), 10'(chain_at(start, stride, NODES - 1))};
    send_word(w, 1'b0, '0);
    w = '{KIND_ADD, 10'(chain_at(start, stride, 6)), 10'(chain_at(start, stride, 5))};
    send_word(w, 1'b0, '0);
    w = '{KIND_QUERY, 10'(chain_at(start, stride, 6)), 10'(chain_at(start, stride, NODES - 1))};
    send_word(w, 1'b0, '0);
    w = '{KIND_QUERY, 10'(chain_at(start, stride, 5)), 10'(chain_at(start, stride, 6))};
    send_word(w, 1'b0, '0);
    w = '{KIND_QUERY, 10'(chain_at(start, stride, 6)), 10'(chain_at(start, stride, 500))};
    send_word(w, 1'b0, '0);
    req_valid <= 1'b0;

    // drain, then give stray words time to show up
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+hdl
hdl/lca_pkg.sv
hdl/lca_ram.sv
hdl/lca_binary_lifting_top.sv
hdl/lca_checker.sv
verif/tb_lca_binary_lifting_top.sv
